>>> hw/rtl/first_fit_extent_allocator_core_assert.svh
// Assertion helpers included by the allocator controller.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_CORE_ASSERT_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_CORE_ASSERT_SVH

// Checked only out of reset.
`define FFEA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define FFEA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> hw/rtl/ffea_pkg.sv
package ffea_pkg;

  localparam int MAX_EXTENTS = 16;
  localparam int IDX_W       = $clog2(MAX_EXTENTS);
  localparam int CNT_W       = $clog2(MAX_EXTENTS + 1);
  localparam int ADDR_W      = 16;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] CFG_DATA_START = 2'd0;
  localparam logic [1:0] CFG_MEM_LENGTH = 2'd1;

  localparam logic [ADDR_W-1:0] MEM_LENGTH_RST = 16'd1024;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } ffea_state_e;

  typedef struct packed {
    logic insert;
    logic clear;
  } ffea_tbl_cmd_t;

endpackage

>>> hw/rtl/ffea_gap.sv
module ffea_gap import ffea_pkg::*; (
  input  logic [ADDR_W-1:0] lo_i,
  input  logic [ADDR_W-1:0] hi_i,
  input  logic [ADDR_W-1:0] size_i,
  output logic              fits_o
);

  logic [ADDR_W:0] diff;

  // borrow flags a reversed gap
  assign diff   = {1'b0, hi_i} - {1'b0, lo_i};
  assign fits_o = !diff[ADDR_W] && (diff[ADDR_W-1:0] >= size_i);

endmodule

>>> hw/rtl/ffea_table.sv
module ffea_table import ffea_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ffea_tbl_cmd_t       cmd_i,
  input  logic [ADDR_W-1:0]   ext_start_i,
  input  logic [ADDR_W-1:0]   ext_length_i,
  input  logic [CNT_W-1:0]    rd_idx_i,
  output logic [CNT_W-1:0]    count_o,
  output logic [ADDR_W-1:0]   beg_rd_o,
  output logic [ADDR_W-1:0]   fin_prev_o
);

  logic [ADDR_W-1:0] beg_q [MAX_EXTENTS];
  logic [ADDR_W-1:0] fin_q [MAX_EXTENTS];
  logic [CNT_W-1:0]  count_q, count_d;
  logic [ADDR_W:0]   end_sum;
  logic [ADDR_W-1:0] ins_fin;
  logic [MAX_EXTENTS-1:0] gt;
  logic [MAX_EXTENTS-1:0] take_new;
  logic              wr_en;
  logic [CNT_W-1:0]  prev_idx;

  assign end_sum = {1'b0, ext_start_i} + {1'b0, ext_length_i};
  assign ins_fin = end_sum[ADDR_W] ? {ADDR_W{1'b1}} : end_sum[ADDR_W-1:0];
  assign wr_en   = cmd_i.insert && (count_q < CNT_W'(MAX_EXTENTS));

  // kept sorted by start; equal starts stay in load order
  always_comb begin
    for (int k = 0; k < MAX_EXTENTS; k++) begin
      gt[k] = (CNT_W'(k) < count_q) && (beg_q[k] > ext_start_i);
    end
    take_new[0] = gt[0] || (count_q == '0);
    for (int k = 1; k < MAX_EXTENTS; k++) begin
      take_new[k] = !gt[k-1] && (gt[k] || (CNT_W'(k) == count_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (take_new[0]) begin
        beg_q[0] <= ext_start_i;
        fin_q[0] <= ins_fin;
      end
      for (int k = 1; k < MAX_EXTENTS; k++) begin
        if (gt[k-1]) begin
          beg_q[k] <= beg_q[k-1];
          fin_q[k] <= fin_q[k-1];
        end else if (take_new[k]) begin
          beg_q[k] <= ext_start_i;
          fin_q[k] <= ins_fin;
        end
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign prev_idx   = rd_idx_i - CNT_W'(1);
  assign beg_rd_o   = beg_q[rd_idx_i[IDX_W-1:0]];
  assign fin_prev_o = fin_q[prev_idx[IDX_W-1:0]];
  assign count_o    = count_q;

endmodule

>>> hw/rtl/ffea_ctrl.sv
module ffea_ctrl import ffea_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                opcode_i,
  input  logic [ADDR_W-1:0]   request_size_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                found_o,
  output logic [ADDR_W-1:0]   free_address_o,
  output ffea_tbl_cmd_t       tbl_cmd_o,
  output logic [CNT_W-1:0]    idx_o,
  output logic [ADDR_W-1:0]   size_o,
  input  logic [CNT_W-1:0]    count_i,
  input  logic                fits_i,
  input  logic [ADDR_W-1:0]   gap_lo_i
);

  ffea_state_e       state_q, state_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [ADDR_W-1:0] size_q;
  logic              out_valid_q, out_valid_d;
  logic              found_q;
  logic [ADDR_W-1:0] addr_q;
  logic              in_acc;
  logic              done;
  logic              out_free;
  logic              out_load;

  assign in_acc   = in_valid_i && in_ready_o;
  assign done     = fits_i || (idx_q == count_i);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc && (opcode_i == OP_QUERY)) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (done && out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    tbl_cmd_o.insert = 1'b0;
    tbl_cmd_o.clear  = 1'b0;
    out_load         = 1'b0;
    idx_d            = idx_q;
    case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        tbl_cmd_o.insert = in_acc && (opcode_i == OP_LOAD);
        idx_d            = '0;
      end
      ST_SCAN: begin
        if (done) begin
          out_load        = out_free;
          tbl_cmd_o.clear = out_free;
        end else begin
          idx_d = idx_q + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      size_q <= request_size_i;
    end
    if (out_load) begin
      found_q <= fits_i;
      addr_q  <= fits_i ? gap_lo_i : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign free_address_o = addr_q;
  assign idx_o          = idx_q;
  assign size_o         = size_q;

`include "first_fit_extent_allocator_core_assert.svh"

  `FFEA_ASSERT(a_scan_in_range, (state_q == ST_SCAN) |-> (idx_q <= count_i), "scan past table")
  `FFEA_ASSERT(a_query_starts, (in_acc && (opcode_i == OP_QUERY)) |=> ((state_q == ST_SCAN) && (idx_q == '0)), "query did not start scan")
  `FFEA_ASSERT(a_no_overwrite, out_load |-> out_free, "result overwritten")
  `FFEA_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> ((state_q == ST_IDLE) && !out_valid_q), "not idle in reset")

endmodule

>>> hw/rtl/first_fit_extent_allocator_core.sv
// First-fit extent allocator. Load beats (opcode 0) insert a used extent into a
// 16-entry table kept sorted by start address; loads beyond a full table are
// dropped. A query beat (opcode 1) scans the gaps in address order, data_start to
// the first extent, between neighbors, and the last extent to memory_length, one
// gap per cycle through a single shared subtract/compare unit. A query keeps the
// input stalled while it scans and while its result beat waits for the previous
// one to drain, returns one result beat (found, free_address) and empties the
// table. Configuration writes go through at any time but should be issued only
// while the block is idle.
module first_fit_extent_allocator_core import ffea_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] opcode, [16:1] extent_start, [32:17] extent_length, [48:33] request_size
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] found, [16:1] free_address
  output logic [23:0] m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [ADDR_W-1:0] data_start_q;
  logic [ADDR_W-1:0] mem_length_q;
  ffea_tbl_cmd_t     tbl_cmd;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  count;
  logic [ADDR_W-1:0] beg_rd;
  logic [ADDR_W-1:0] fin_prev;
  logic [ADDR_W-1:0] size;
  logic [ADDR_W-1:0] gap_lo;
  logic [ADDR_W-1:0] gap_hi;
  logic              fits;
  logic              found;
  logic [ADDR_W-1:0] free_address;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_q <= '0;
      mem_length_q <= MEM_LENGTH_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DATA_START: data_start_q <= cfg_data_i;
        CFG_MEM_LENGTH: mem_length_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ffea_table u_table (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (tbl_cmd),
    .ext_start_i  (s_axis_tdata[16:1]),
    .ext_length_i (s_axis_tdata[32:17]),
    .rd_idx_i     (idx),
    .count_o      (count),
    .beg_rd_o     (beg_rd),
    .fin_prev_o   (fin_prev)
  );

  assign gap_lo = (idx == '0) ? data_start_q : fin_prev;
  assign gap_hi = (idx == count) ? mem_length_q : beg_rd;

  ffea_gap u_gap (
    .lo_i   (gap_lo),
    .hi_i   (gap_hi),
    .size_i (size),
    .fits_o (fits)
  );

  ffea_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .opcode_i       (s_axis_tdata[0]),
    .request_size_i (s_axis_tdata[48:33]),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .found_o        (found),
    .free_address_o (free_address),
    .tbl_cmd_o      (tbl_cmd),
    .idx_o          (idx),
    .size_o         (size),
    .count_i        (count),
    .fits_i         (fits),
    .gap_lo_i       (gap_lo)
  );

  assign m_axis_tdata = {7'd0, free_address, found};

endmodule
